// ----- design/bdq_pkg.sv -----
// Shared definitions for the bounded deque: request and status codes,
// cell operation codes and word-layout constants.
// No dependencies.
package bdq_pkg;

   localparam int DEPTH_DEF      = 8;
   localparam int DATA_WIDTH_DEF = 32;

   // field widths on the stream ports
   localparam int TYPE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 3;
   localparam int STATUS_W = 2;
   localparam int CNT_O_W  = 4;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = TYPE_W;
   localparam int RSP_DATA_W = 112;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_WRITE      = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_READ       = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_CLEAR      = 3'd6;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

   // what every cell of the row does on a given cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN,
      CELL_LOAD,
      CELL_ZERO,
      CELL_CLEAR
   } cell_op_type;

endpackage

// ----- design/bdq_cell.sv -----
// One storage cell of the deque row: holds one entry, takes from either
// neighbor on a shift, and drives its entry onto two read taps.
// Depends on bdq_pkg.
module bdq_cell #(
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
   parameter int POS_W      = 3,
   parameter int POS        = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bdq_pkg::cell_op_type    op,
   input  logic [POS_W-1:0]        pos,
   input  logic [DATA_WIDTH-1:0]   load_data,
   input  logic [DATA_WIDTH-1:0]   up_data,
   input  logic [DATA_WIDTH-1:0]   down_data,
   input  logic [POS_W-1:0]        rd_pos,
   input  logic [POS_W-1:0]        back_pos,
   output logic [DATA_WIDTH-1:0]   entry_out,
   output logic [DATA_WIDTH-1:0]   rd_tap,
   output logic [DATA_WIDTH-1:0]   back_tap
);
   import bdq_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;
   logic                  hit;

   assign hit = (pos == MY_POS);

   always_comb begin
      unique case (op)
         CELL_HOLD:       entry_in = entry_ff;
         CELL_SHIFT_UP:   entry_in = up_data;
         CELL_SHIFT_DOWN: entry_in = down_data;
         CELL_LOAD:       entry_in = hit ? load_data : entry_ff;
         CELL_ZERO:       entry_in = hit ? '0 : entry_ff;
         CELL_CLEAR:      entry_in = '0;
         default:         entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;
   assign rd_tap    = (rd_pos == MY_POS) ? entry_ff : '0;
   assign back_tap  = (back_pos == MY_POS) ? entry_ff : '0;

endmodule

// ----- design/bounded_array_deque_top.sv -----
// Bounded deque top level: request decode, occupancy count, the cell row
// and the result register stage.
// Depends on bdq_pkg and bdq_cell.

// A fixed-capacity deque of DEPTH entries kept in a row of cells that all
// shift in the same cycle. Each request word (push front/back, pop
// front/back, write or read at an index, clear) yields exactly one result
// word with the status, the popped or read entry, and the front, back,
// count, free slots, empty and full flags after the request. One request
// is taken every cycle: the whole row and the count update at the accept
// edge, and the result is presented on the rsp channel from the result
// register (the accept edge updates the row and captures status in stage
// one; when stage one advances, front, back and count are snapshotted).
// A stalled rsp side holds the request side once two words are pending.
// Storage and count reset to zero.
module bounded_array_deque_top #(
   parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // value[31:0], index[34:32], zero pad
   input  logic [bdq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type[2:0]
   input  logic [bdq_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[1:0], free_slots[5:2], read_value[37:6], front_value[69:38],
   // back_value[101:70], count[105:102], is_empty[106], is_full[107], pad
   output logic [bdq_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bdq_pkg::*;

   localparam int POS_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
   localparam logic [CMP_W-1:0] CMP_DEPTH = CMP_W'(DEPTH);
   localparam int PAD_W = RSP_DATA_W - (STATUS_W + 2 * CNT_O_W + 3 * VALUE_W + 2);

   // request fields
   logic [TYPE_W-1:0]     kind;
   logic [DATA_WIDTH-1:0] value_d;
   logic [INDEX_W-1:0]    index;

   // control and count
   logic [CNT_W-1:0]      occ_ff;
   logic [CNT_W-1:0]      occ_in;
   logic [CNT_W-1:0]      occ_nx;
   logic                  full;
   logic                  empty;
   logic [CMP_W-1:0]      idx_cmp;
   logic [CMP_W-1:0]      occ_cmp;
   logic                  idx_ok;
   logic [POS_W-1:0]      last_pos;
   logic                  req_fire;
   logic                  s1_advance;

   // decode results
   cell_op_type           op_nx;
   cell_op_type           cell_op;
   logic [POS_W-1:0]      cell_pos;
   logic [POS_W-1:0]      rd_pos;
   logic                  rd_take;
   logic [STATUS_W-1:0]   status_nx;

   // cell row
   logic [DATA_WIDTH-1:0] entry  [DEPTH];
   logic [DATA_WIDTH-1:0] rd_tap [DEPTH];
   logic [DATA_WIDTH-1:0] bk_tap [DEPTH];
   logic [DATA_WIDTH-1:0] rd_value;
   logic [DATA_WIDTH-1:0] back_raw;

   // stage one: status and popped/read entry
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [STATUS_W-1:0]   s1_status_ff;
   logic [DATA_WIDTH-1:0] s1_rd_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   assign kind    = req_tuser;
   assign value_d = DATA_WIDTH'(req_tdata[VALUE_W-1:0]);
   assign index   = req_tdata[VALUE_W +: INDEX_W];

   assign full     = (occ_ff == CNT_FULL);
   assign empty    = (occ_ff == '0);
   assign idx_cmp  = CMP_W'(index);
   assign occ_cmp  = CMP_W'(occ_ff);
   assign idx_ok   = (idx_cmp < CMP_DEPTH);
   assign last_pos = POS_W'(occ_ff - CNT_W'(1));

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      op_nx     = CELL_HOLD;
      cell_pos  = '0;
      rd_pos    = '0;
      rd_take   = 1'b0;
      status_nx = ST_OK;
      occ_nx    = occ_ff;
      unique case (kind)
         REQ_PUSH_FRONT: begin
            if (full) begin
               status_nx = ST_FULL;
            end else begin
               op_nx  = CELL_SHIFT_UP;
               occ_nx = occ_ff + CNT_W'(1);
            end
         end
         REQ_PUSH_BACK: begin
            if (full) begin
               status_nx = ST_FULL;
            end else begin
               op_nx    = CELL_LOAD;
               cell_pos = POS_W'(occ_ff);
               occ_nx   = occ_ff + CNT_W'(1);
            end
         end
         REQ_POP_FRONT: begin
            if (empty) begin
               status_nx = ST_EMPTY;
            end else begin
               op_nx   = CELL_SHIFT_DOWN;
               rd_take = 1'b1;
               occ_nx  = occ_ff - CNT_W'(1);
            end
         end
         REQ_POP_BACK: begin
            if (empty) begin
               status_nx = ST_EMPTY;
            end else begin
               op_nx    = CELL_ZERO;
               cell_pos = last_pos;
               rd_pos   = last_pos;
               rd_take  = 1'b1;
               occ_nx   = occ_ff - CNT_W'(1);
            end
         end
         REQ_WRITE: begin
            // writing one past the last entry is allowed
            if (!idx_ok || (idx_cmp > occ_cmp)) begin
               status_nx = ST_BAD_INDEX;
            end else begin
               op_nx    = CELL_LOAD;
               cell_pos = POS_W'(index);
            end
         end
         REQ_READ: begin
            if (!idx_ok || (idx_cmp >= occ_cmp)) begin
               status_nx = ST_BAD_INDEX;
            end else begin
               rd_pos  = POS_W'(index);
               rd_take = 1'b1;
            end
         end
         REQ_CLEAR: begin
            op_nx  = CELL_CLEAR;
            occ_nx = '0;
         end
         default: begin
         end
      endcase
   end

   assign cell_op = req_fire ? op_nx : CELL_HOLD;
   assign occ_in  = req_fire ? occ_nx : occ_ff;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [DATA_WIDTH-1:0] up_d;
         logic [DATA_WIDTH-1:0] down_d;
         if (gi == 0) begin : g_first
            assign up_d = value_d;
         end else begin : g_mid_up
            assign up_d = entry[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign down_d = '0;
         end else begin : g_mid_down
            assign down_d = entry[gi+1];
         end
         bdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .POS_W      (POS_W),
            .POS        (gi)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .op        (cell_op),
            .pos       (cell_pos),
            .load_data (value_d),
            .up_data   (up_d),
            .down_data (down_d),
            .rd_pos    (rd_pos),
            .back_pos  (last_pos),
            .entry_out (entry[gi]),
            .rd_tap    (rd_tap[gi]),
            .back_tap  (bk_tap[gi])
         );
      end
   endgenerate

   // only the addressed cell drives a nonzero tap
   always_comb begin
      rd_value = '0;
      back_raw = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_value = rd_value | rd_tap[i];
         back_raw = back_raw | bk_tap[i];
      end
   end

   assign s1_valid_in = req_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         occ_ff      <= occ_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_status_ff <= status_nx;
         s1_rd_ff     <= rd_take ? rd_value : '0;
      end
   end

   // the row now shows the state after the stage-one request
   always_comb begin
      logic [DATA_WIDTH-1:0] front_v;
      logic [DATA_WIDTH-1:0] back_v;
      logic [CNT_W-1:0]      free_v;
      front_v = empty ? '0 : entry[0];
      back_v  = empty ? '0 : back_raw;
      free_v  = CNT_FULL - occ_ff;
      rsp_data_in = {PAD_W'(0), full, empty, CNT_O_W'(occ_ff), VALUE_W'(back_v),
                     VALUE_W'(front_v), VALUE_W'(s1_rd_ff), CNT_O_W'(free_v),
                     s1_status_ff};
   end

   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_FULL)
      else $error("occupancy above capacity");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (req_fire && full && ((kind == REQ_PUSH_FRONT) || (kind == REQ_PUSH_BACK)))
      |=> $stable(occ_ff))
      else $error("rejected push changed occupancy");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (kind == REQ_CLEAR)) |=> (occ_ff == '0) && (entry[0] == '0))
      else $error("clear left entries behind");

   a_stage_out: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("stage-one word lost before result register");

endmodule
